// ===== sv/tmtp_pkg.sv =====
// tmtp_pkg: shared types, constants and helper functions of the thue-morse turtle plotter
// used by every module of the block; depends on nothing
package tmtp_pkg;

    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int COUNT_BITS     = 16;
    localparam int BITS_PER_GROUP = 3;

    localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DIM_BITS  = 13;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [31:0] TM_FLIP_MASK = 32'h5555_5555;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TURN_TABLE    = 3'd5;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
    } in_word_t;

    typedef struct packed {
        logic [15:0]        cell_count;
        logic [2:0]         cell_heading;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic [2:0]         heading;
        logic               on_canvas;
        logic               walk_done;
    } out_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [2:0]            dir;
    } cell_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic restart;
        logic clr_wr;
        logic offs;
        logic look;
        logic mark;
        logic turn;
        logic rd_issue;
        logic rd_fetch;
        logic seq_adv;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic clr_last;
        logic out_free;
    } dp_sts_t;

    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [8:0] size, input int max_size);
        logic [DIM_BITS-1:0] ext;
        ext = DIM_BITS'(size);
        if (ext > DIM_BITS'(max_size)) begin
            return DIM_BITS'(max_size);
        end
        return ext;
    endfunction

    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] lin;
        lin = y * 32'(MAX_WIDTH) + x;
        return lin[ADDR_BITS-1:0];
    endfunction

    function automatic logic [15:0] sat_count(input logic [COUNT_BITS-1:0] count);
        if (COUNT_BITS > 16 && 32'(count) > 32'hFFFF) begin
            return 16'hFFFF;
        end
        return 16'(count);
    endfunction

    function automatic logic [31:0] step_dx(input logic [2:0] h);
        logic [31:0] d;
        unique case (h)
            3'd0, 3'd1, 3'd7: d = 32'd1;
            3'd2, 3'd6:       d = 32'd0;
            default:          d = 32'hFFFF_FFFF;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] step_dy(input logic [2:0] h);
        logic [31:0] d;
        unique case (h)
            3'd1, 3'd2, 3'd3: d = 32'd1;
            3'd0, 3'd4:       d = 32'd0;
            default:          d = 32'hFFFF_FFFF;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/tmtp_canvas.sv =====
// tmtp_canvas: canvas store, one write port and one registered read port
// depends on tmtp_pkg
module tmtp_canvas (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [tmtp_pkg::ADDR_BITS-1:0] wr_addr,
    input  tmtp_pkg::cell_t                wr_data,
    input  logic                           rd_en,
    input  logic [tmtp_pkg::ADDR_BITS-1:0] rd_addr,
    output tmtp_pkg::cell_t                rd_data
);
    import tmtp_pkg::*;

    cell_t canvas_mem [CELLS];
    cell_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            canvas_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= canvas_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tmtp_datapath.sv =====
// tmtp_datapath: configuration registers, walk state, sequence unit, canvas access
// and the output register; depends on tmtp_pkg and tmtp_canvas
module tmtp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tmtp_pkg::dp_cmd_t                   cmd,
    output tmtp_pkg::dp_sts_t                   sts,
    input  tmtp_pkg::in_word_t                  s_word,
    input  logic                                cfg_valid,
    input  logic [tmtp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tmtp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tmtp_pkg::out_word_t                 m_word
);
    import tmtp_pkg::*;

    // configuration
    logic [8:0]         canvas_width_reg, canvas_height_reg;
    logic signed [15:0] offset_x_reg, offset_y_reg;
    logic [23:0]        step_limit_reg, turn_table_reg;

    // walk state
    logic [31:0] seq_idx_reg;
    logic        seq_bit_reg;
    logic [2:0]  group_reg;
    logic [2:0]  heading_reg;
    logic [31:0] walk_x_reg, walk_y_reg;
    logic [23:0] steps_reg;
    logic [ADDR_BITS-1:0] sweep_reg;

    // per item
    logic [7:0]            cell_x_reg, cell_y_reg;
    logic [32:0]           sx_reg, sy_reg;
    logic                  hit_reg, rd_hit_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [COUNT_BITS-1:0] res_count_reg;
    logic [2:0]            res_dir_reg;
    logic                  res_mark_reg;
    logic                  m_valid_reg;
    out_word_t             m_word_reg;

    logic [DIM_BITS-1:0]  eff_w, eff_h;
    logic                 step_hit, read_hit;
    logic [ADDR_BITS-1:0] step_addr, read_addr;
    logic [31:0]          low_bit;
    logic                 seq_bit_next;
    logic [2:0]           turn, heading_next;
    cell_t                rd_cell, new_cell, wr_cell;
    logic                 wr_en, rd_en;
    logic [ADDR_BITS-1:0] wr_addr, rd_addr;

    assign eff_w = eff_dim(canvas_width_reg, MAX_WIDTH);
    assign eff_h = eff_dim(canvas_height_reg, MAX_HEIGHT);

    assign step_hit = !sx_reg[32] && !sy_reg[32]
                    && (sx_reg[31:0] < 32'(eff_w)) && (sy_reg[31:0] < 32'(eff_h));
    assign read_hit = (DIM_BITS'(cell_x_reg) < eff_w) && (DIM_BITS'(cell_y_reg) < eff_h);
    assign step_addr = cell_addr(sx_reg[31:0], sy_reg[31:0]);
    assign read_addr = cell_addr(32'(cell_x_reg), 32'(cell_y_reg));

    // lowest set bit at an even position flips the thue-morse bit
    assign low_bit      = seq_idx_reg & (~seq_idx_reg + 32'd1);
    assign seq_bit_next = seq_bit_reg ^ (|(low_bit & TM_FLIP_MASK));

    assign turn         = turn_table_reg[3*group_reg +: 3];
    assign heading_next = heading_reg + turn;

    always_comb begin
        new_cell = rd_cell;
        if (rd_cell.count == '0) begin
            new_cell.count = COUNT_BITS'(1);
            new_cell.dir   = heading_reg;
        end else if (rd_cell.count != COUNT_MAX) begin
            new_cell.count = rd_cell.count + COUNT_BITS'(1);
        end
    end

    assign wr_en   = cmd.clr_wr || (cmd.mark && hit_reg);
    assign wr_addr = cmd.clr_wr ? sweep_reg : addr_reg;
    assign wr_cell = cmd.clr_wr ? '0 : new_cell;
    assign rd_en   = cmd.look || cmd.rd_issue;
    assign rd_addr = cmd.rd_issue ? read_addr : step_addr;

    tmtp_canvas u_canvas (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_cell),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_cell)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg  <= 9'd256;
            canvas_height_reg <= 9'd256;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            step_limit_reg    <= '0;
            turn_table_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[8:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[8:0];
                REG_OFFSET_X:      offset_x_reg      <= $signed(cfg_data[15:0]);
                REG_OFFSET_Y:      offset_y_reg      <= $signed(cfg_data[15:0]);
                REG_STEP_LIMIT:    step_limit_reg    <= cfg_data;
                REG_TURN_TABLE:    turn_table_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_idx_reg <= '0;
            seq_bit_reg <= 1'b0;
            heading_reg <= '0;
            walk_x_reg  <= '0;
            walk_y_reg  <= '0;
            steps_reg   <= '0;
            sweep_reg   <= '0;
        end else begin
            if (cmd.restart) begin
                seq_idx_reg <= '0;
                seq_bit_reg <= 1'b0;
                heading_reg <= '0;
                walk_x_reg  <= '0;
                walk_y_reg  <= '0;
                steps_reg   <= '0;
            end
            if (cmd.seq_adv) begin
                seq_idx_reg <= seq_idx_reg + 32'd1;
                seq_bit_reg <= seq_bit_next;
            end
            if (cmd.turn) begin
                heading_reg <= heading_next;
                walk_x_reg  <= walk_x_reg + step_dx(heading_next);
                walk_y_reg  <= walk_y_reg + step_dy(heading_next);
                steps_reg   <= steps_reg + 24'd1;
            end
            if (cmd.clr_wr) begin
                sweep_reg <= sts.clr_last ? '0 : sweep_reg + ADDR_BITS'(1);
            end
        end
    end

    // per item payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            cell_x_reg    <= s_word.cell_x;
            cell_y_reg    <= s_word.cell_y;
            res_count_reg <= '0;
            res_dir_reg   <= '0;
            res_mark_reg  <= 1'b0;
        end
        if (cmd.seq_adv) begin
            group_reg <= {group_reg[1:0], seq_bit_next};
        end
        if (cmd.offs) begin
            sx_reg <= {walk_x_reg[31], walk_x_reg} + 33'($signed(offset_x_reg));
            sy_reg <= {walk_y_reg[31], walk_y_reg} + 33'($signed(offset_y_reg));
        end
        if (cmd.look) begin
            hit_reg  <= step_hit;
            addr_reg <= step_addr;
        end
        if (cmd.rd_issue) begin
            rd_hit_reg <= read_hit;
        end
        if (cmd.mark && hit_reg) begin
            res_count_reg <= new_cell.count;
            res_dir_reg   <= new_cell.dir;
            res_mark_reg  <= 1'b1;
        end
        if (cmd.rd_fetch && rd_hit_reg) begin
            res_count_reg <= rd_cell.count;
            res_dir_reg   <= rd_cell.dir;
        end
        if (cmd.load_out) begin
            m_word_reg.cell_count   <= sat_count(res_count_reg);
            m_word_reg.cell_heading <= res_dir_reg;
            m_word_reg.position_x   <= $signed(walk_x_reg);
            m_word_reg.position_y   <= $signed(walk_y_reg);
            m_word_reg.heading      <= heading_reg;
            m_word_reg.on_canvas    <= res_mark_reg;
            m_word_reg.walk_done    <= (steps_reg >= step_limit_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.walk_done = (steps_reg >= step_limit_reg);
    assign sts.clr_last  = (sweep_reg == ADDR_BITS'(CELLS - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a word not yet taken");

    a_mark_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mark && hit_reg |-> new_cell.count != '0)
        else $error("marked cell written with zero count");

    a_sweep_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr && sts.clr_last |=> sweep_reg == '0)
        else $error("clear sweep did not return to first cell");

endmodule

// ===== sv/tmtp_ctrl.sv =====
// tmtp_ctrl: sequencing state machine of the plotter, issues datapath commands
// depends on tmtp_pkg
module tmtp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  tmtp_pkg::dp_sts_t   sts,
    output tmtp_pkg::dp_cmd_t   cmd
);
    import tmtp_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_OFFS,
        ST_LOOK,
        ST_MARK,
        ST_TURN,
        ST_READ,
        ST_RDAT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign take    = (state_reg == ST_IDLE) && s_valid;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  if (sts.clr_last) begin
                          state_next = ST_IDLE;
                      end
            ST_IDLE:  if (s_valid) begin
                          unique case (s_command)
                              CMD_CLEAR: state_next = ST_CLEAR;
                              CMD_STEP:  state_next = sts.walk_done ? ST_DONE : ST_OFFS;
                              CMD_READ:  state_next = ST_READ;
                              default:   state_next = ST_DONE;
                          endcase
                      end
            ST_CLEAR: if (sts.clr_last) begin
                          state_next = ST_DONE;
                      end
            ST_OFFS:  state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_MARK;
            ST_MARK:  state_next = ST_TURN;
            ST_TURN:  state_next = ST_DONE;
            ST_READ:  state_next = ST_RDAT;
            ST_RDAT:  state_next = ST_DONE;
            ST_DONE:  if (sts.out_free) begin
                          state_next = ST_IDLE;
                      end
            default:  state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.take     = take;
        cmd.restart  = take && (s_command == CMD_CLEAR);
        cmd.clr_wr   = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        cmd.offs     = (state_reg == ST_OFFS);
        cmd.look     = (state_reg == ST_LOOK);
        cmd.mark     = (state_reg == ST_MARK);
        cmd.turn     = (state_reg == ST_TURN);
        cmd.rd_issue = (state_reg == ST_READ);
        cmd.rd_fetch = (state_reg == ST_RDAT);
        cmd.seq_adv  = (state_reg == ST_OFFS) || (state_reg == ST_LOOK)
                    || (state_reg == ST_MARK);
        cmd.load_out = (state_reg == ST_DONE) && sts.out_free;
    end

    a_take_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted word did not start work");

    a_three_group_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TURN |-> $past(cmd.seq_adv) && $past(cmd.seq_adv, 2)
                                 && $past(cmd.seq_adv, 3))
        else $error("turn taken before a full group was drawn");

    a_clear_ends_in_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR && sts.clr_last |=> state_reg == ST_DONE)
        else $error("restart finished without a result");

endmodule

// ===== sv/thue_morse_turtle_plotter.sv =====
// thue_morse_turtle_plotter: top level, ties controller and datapath to the ports
// depends on tmtp_pkg, tmtp_ctrl, tmtp_datapath
//
// One item is worked at a time and each item gives one result word. A step runs from
// acceptance through offset add, canvas read and read-modify-write of the cell while
// the sequence unit draws one bit a cycle, then turn and move; a cell read issues the
// read, then fetches the cell, and an unused command or a step past the limit goes
// straight to the result. The canvas is a single memory with one write and one
// registered read port, and both reset and a restart command clear it one cell a
// cycle; no input word is accepted until the clear after reset has finished.
// Configuration writes are taken every cycle and must only be made while idle.
module thue_morse_turtle_plotter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tmtp_pkg::in_word_t                   s_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tmtp_pkg::out_word_t                  m_word,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tmtp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tmtp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tmtp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    tmtp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_word.command),
        .sts       (sts),
        .cmd       (cmd)
    );

    tmtp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_word    (s_word),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule
